// ===== design/mom_pkg.sv =====
// Shared types, operation codes and limits for the move operation merger.
`timescale 1ns / 1ps

package mom_pkg;

	localparam int CMD_DEPTH = 2;
	localparam int RES_DEPTH = 2;

	localparam logic [3:0] OP_CAP_LEN  = 4'd0;
	localparam logic [3:0] OP_CAP_CHR  = 4'd1;
	localparam logic [3:0] OP_CAP_END  = 4'd2;
	localparam logic [3:0] OP_SKIP     = 4'd3;
	localparam logic [3:0] OP_GOTO_ABS = 4'd4;
	localparam logic [3:0] OP_GOTO_END = 4'd5;
	localparam logic [3:0] OP_FWD      = 4'd6;
	localparam logic [3:0] OP_BACK     = 4'd7;
	localparam logic [3:0] OP_SEEK_FWD = 4'd8;
	localparam logic [3:0] OP_SEEK_REV = 4'd9;

	localparam logic [3:0] EX_SKIP = 4'd3;
	localparam logic [3:0] EX_FWD  = 4'd6;
	localparam logic [3:0] EX_BACK = 4'd7;
	localparam logic [3:0] EX_DONE = 4'd10;

	localparam logic signed [32:0] SUM_MAX = 33'sd2147483647;
	localparam logic signed [32:0] SUM_MIN = -33'sd2147483647;
	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	typedef struct packed {
		logic        action;
		logic [3:0]  op_kind;
		logic [15:0] operand;
		logic [7:0]  search_char;
		logic        from_end_flag;
	} item_t;

	typedef struct packed {
		logic [3:0]  ex_kind;
		logic [30:0] amount;
		logic [7:0]  out_char;
		logic        out_from_end;
		logic [15:0] capture_count;
		logic        last_of_run;
	} result_t;

	typedef struct packed {
		logic    has_flush;
		result_t flush_res;
		result_t main_res;
	} cmd_t;

endpackage

// ===== design/mom_fifo.sv =====
// Small register FIFO used between the front end, back end and result port.
`timescale 1ns / 1ps

module mom_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ===== design/mom_front.sv =====
// Front end: classifies items, merges relative moves and builds commands.
`timescale 1ns / 1ps

module mom_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  mom_pkg::item_t item,
	output logic           cmd_push,
	output mom_pkg::cmd_t  cmd
);

	logic               seg_open_q;
	logic signed [31:0] seg_sum_q;
	logic               seg_skip_q;
	logic [15:0]        captures_q;

	logic               is_move;
	logic               is_valid;
	logic               is_capture;
	logic signed [31:0] sum_base;
	logic signed [32:0] addend;
	logic signed [32:0] sum_wide;
	logic signed [31:0] sum_next;
	logic               sum_neg;
	logic [31:0]        sum_mag;
	logic               flush_skip;
	logic [15:0]        cap_next;

	assign is_move    = (item.op_kind == mom_pkg::OP_SKIP) ||
	                    (item.op_kind == mom_pkg::OP_FWD) ||
	                    (item.op_kind == mom_pkg::OP_BACK);
	assign is_valid   = (item.op_kind <= mom_pkg::OP_SEEK_REV);
	assign is_capture = (item.op_kind <= mom_pkg::OP_CAP_END);

	assign sum_base = seg_open_q ? seg_sum_q : 32'sd0;
	assign addend   = (item.op_kind == mom_pkg::OP_BACK) ?
	                  -$signed({17'd0, item.operand}) : $signed({17'd0, item.operand});
	assign sum_wide = $signed({sum_base[31], sum_base}) + addend;

	always_comb begin
		priority if (sum_wide > mom_pkg::SUM_MAX) begin
			sum_next = 32'(mom_pkg::SUM_MAX);
		end else if (sum_wide < mom_pkg::SUM_MIN) begin
			sum_next = 32'(mom_pkg::SUM_MIN);
		end else begin
			sum_next = sum_wide[31:0];
		end
	end

	assign sum_neg    = seg_sum_q[31];
	assign sum_mag    = sum_neg ? 32'(-seg_sum_q) : 32'(seg_sum_q);
	assign flush_skip = seg_skip_q && !sum_neg;
	assign cap_next   = (is_capture && captures_q != mom_pkg::COUNT_MAX) ?
	                    captures_q + 16'd1 : captures_q;

	always_comb begin
		cmd = '0;
		cmd.has_flush = seg_open_q && (flush_skip || seg_sum_q != 32'sd0);
		cmd.flush_res.ex_kind = flush_skip ? mom_pkg::EX_SKIP :
		                        (sum_neg ? mom_pkg::EX_BACK : mom_pkg::EX_FWD);
		cmd.flush_res.amount = sum_mag[30:0];
		cmd.flush_res.capture_count = captures_q;
		cmd.main_res.last_of_run = 1'b1;
		if (item.action) begin
			cmd.main_res.ex_kind = mom_pkg::EX_DONE;
			cmd.main_res.capture_count = captures_q;
		end else begin
			cmd.main_res.ex_kind = item.op_kind;
			cmd.main_res.capture_count = cap_next;
			unique case (item.op_kind)
				mom_pkg::OP_CAP_LEN, mom_pkg::OP_GOTO_ABS: begin
					cmd.main_res.amount = {15'd0, item.operand};
				end
				mom_pkg::OP_GOTO_END: begin
					cmd.main_res.amount = {15'd0, item.operand};
					cmd.main_res.out_from_end = item.from_end_flag;
				end
				mom_pkg::OP_CAP_CHR, mom_pkg::OP_SEEK_FWD, mom_pkg::OP_SEEK_REV: begin
					cmd.main_res.out_char = item.search_char;
				end
				default: begin
				end
			endcase
		end
	end

	assign cmd_push = accept && (item.action || (is_valid && !is_move));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_open_q <= 1'b0;
			seg_sum_q  <= '0;
			seg_skip_q <= 1'b0;
			captures_q <= '0;
		end else if (accept) begin
			priority if (item.action) begin
				seg_open_q <= 1'b0;
				seg_sum_q  <= '0;
				seg_skip_q <= 1'b0;
				captures_q <= '0;
			end else if (!is_valid) begin
				seg_open_q <= seg_open_q;
			end else if (is_move) begin
				seg_open_q <= 1'b1;
				seg_sum_q  <= sum_next;
				seg_skip_q <= (seg_open_q && seg_skip_q) ||
				              (item.op_kind == mom_pkg::OP_SKIP);
			end else begin
				seg_open_q <= 1'b0;
				seg_sum_q  <= '0;
				seg_skip_q <= 1'b0;
				captures_q <= cap_next;
			end
		end
	end

endmodule

// ===== design/mom_back.sv =====
// Back end: expands each command into its flush and main results.
`timescale 1ns / 1ps

module mom_back (
	input  logic             clk,
	input  logic             arst_n,
	input  mom_pkg::cmd_t    cmd,
	input  logic             cmd_empty,
	output logic             cmd_pop,
	input  logic             res_full,
	output logic             res_push,
	output mom_pkg::result_t res
);

	logic flush_done_q;
	logic send_flush;

	assign send_flush = cmd.has_flush && !flush_done_q;
	assign res_push   = !cmd_empty && !res_full;
	assign cmd_pop    = res_push && !send_flush;
	assign res        = send_flush ? cmd.flush_res : cmd.main_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flush_done_q <= 1'b0;
		end else if (res_push) begin
			flush_done_q <= send_flush;
		end
	end

endmodule

// ===== design/move_op_merger.sv =====
// Results pass the command queue and then the result queue; merged moves surface when flushed.
// Throughput: one item per cycle while the command queue is not full; an item that flushes
// a move run holds the back end while it delivers its flush result before its main result.
// Queues of CMD_DEPTH commands and RES_DEPTH results separate front, back and output.
// Reset (arst_n low, asynchronous): queues empty, move run closed, capture count zero.
`timescale 1ns / 1ps

module move_op_merger #(
	parameter int CMD_DEPTH = mom_pkg::CMD_DEPTH,
	parameter int RES_DEPTH = mom_pkg::RES_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  mom_pkg::item_t   item,
	input  logic             pop,
	output logic             empty,
	output mom_pkg::result_t result
);

	mom_pkg::cmd_t    cmd_w;
	mom_pkg::cmd_t    cmd_r;
	mom_pkg::result_t res_w;
	logic             cmd_push;
	logic             cmd_pop;
	logic             cmd_empty;
	logic             res_push;
	logic             res_full;

	mom_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (push && !full),
		.item     (item),
		.cmd_push (cmd_push),
		.cmd      (cmd_w)
	);

	mom_fifo #(
		.WIDTH ($bits(mom_pkg::cmd_t)),
		.DEPTH (CMD_DEPTH)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_w),
		.full   (full),
		.pop    (cmd_pop),
		.rdata  (cmd_r),
		.empty  (cmd_empty)
	);

	mom_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_r),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_w)
	);

	mom_fifo #(
		.WIDTH ($bits(mom_pkg::result_t)),
		.DEPTH (RES_DEPTH)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_w),
		.full   (res_full),
		.pop    (pop),
		.rdata  (result),
		.empty  (empty)
	);

endmodule
